FILE: design/dtd_pkg.sv
// Shared constants, stage payload types and helper functions for the date converter.
`default_nettype none

package dtd_pkg;

	// Year and month limits of the supported calendar range.
	localparam int unsigned YEAR_FIRST = 1970;
	localparam int unsigned YEAR_LAST = 9999;
	localparam int unsigned MONTH_FIRST = 1;
	localparam int unsigned MONTH_LAST = 12;

	// Day total of the full years 1..1969.
	localparam int unsigned DAYS_BEFORE_EPOCH = 719162;
	localparam int unsigned DAYS_PER_YEAR = 365;

	// Reciprocal of 25 for quotients of values up to 2499.
	localparam int unsigned RECIP_25 = 2622;
	localparam int unsigned RECIP_SHIFT = 16;

	// Month index of February (January is zero).
	localparam logic [3:0] FEB_INDEX = 4'd1;
	localparam logic [4:0] LEAP_FEB_LENGTH = 5'd29;

	// Payload after the first register stage.
	typedef struct packed {
		logic [13:0] prev_year;
		logic [23:0] prod_prev;
		logic [23:0] prod_year;
		logic [11:0] year_quarter;
		logic [1:0]  year_low;
		logic [3:0]  month_index;
		logic [4:0]  day;
	} dtd_s1_t;

	// Payload after the second register stage.
	typedef struct packed {
		logic [21:0] year_days;
		logic        leap;
		logic [3:0]  month_index;
		logic [4:0]  day;
	} dtd_s2_t;

	// Payload after the third register stage.
	typedef struct packed {
		logic [21:0] count;
		logic [21:0] first_index;
		logic        leap;
		logic [4:0]  month_length;
	} dtd_s3_t;

	// Result held in the output stage.
	typedef struct packed {
		logic [21:0] day_count;
		logic [2:0]  weekday;
		logic        leap_year;
		logic [4:0]  month_length;
		logic [2:0]  first_column;
	} dtd_result_t;

	// Days in the months before the given month index of a common year.
	function automatic logic [8:0] days_before_month(input logic [3:0] idx);
		logic [8:0] d;
		begin
			case (idx)
				4'd0: d = 9'd0;
				4'd1: d = 9'd31;
				4'd2: d = 9'd59;
				4'd3: d = 9'd90;
				4'd4: d = 9'd120;
				4'd5: d = 9'd151;
				4'd6: d = 9'd181;
				4'd7: d = 9'd212;
				4'd8: d = 9'd243;
				4'd9: d = 9'd273;
				4'd10: d = 9'd304;
				4'd11: d = 9'd334;
				default: d = 9'd0;
			endcase
			return d;
		end
	endfunction

	// Length of a month of a common year.
	function automatic logic [4:0] plain_month_length(input logic [3:0] idx);
		logic [4:0] l;
		begin
			case (idx)
				4'd1: l = 5'd28;
				4'd3, 4'd5, 4'd8, 4'd10: l = 5'd30;
				default: l = 5'd31;
			endcase
			return l;
		end
	endfunction

	// Remainder by seven through sums of octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [21:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		begin
			s1 = 6'(v[21]);
			for (int i = 0; i < 7; i++) begin
				s1 = s1 + 6'(v[3*i +: 3]);
			end
			s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
			s3 = 3'(s2[3]) + s2[2:0];
			return (s3 == 3'd7) ? 3'd0 : s3;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/dtd_if.sv
// Valid/ready channel interfaces for dates in and results out.
`default_nettype none

interface dtd_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  day_number;
	logic [3:0]  month_number;
	logic [13:0] year_number;

	modport source (output valid, day_number, month_number, year_number, input ready);
	modport sink (input valid, day_number, month_number, year_number, output ready);
endinterface

interface dtd_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] day_count;
	logic [2:0]  weekday;
	logic        leap_year;
	logic [4:0]  month_length;
	logic [2:0]  first_column;

	modport source (output valid, day_count, weekday, leap_year, month_length, first_column,
		input ready);
	modport sink (input valid, day_count, weekday, leap_year, month_length, first_column,
		output ready);
endinterface

`default_nettype wire

FILE: design/dtd_year_calc.sv
// Stages one and two: input clamping, century quotients, leap flag and days before the year.
`default_nettype none

module dtd_year_calc (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire logic [4:0]       day_number,
	input  wire logic [3:0]       month_number,
	input  wire logic [13:0]      year_number,
	output logic                  valid_s2,
	output dtd_pkg::dtd_s2_t      data_s2
);
	import dtd_pkg::*;

	logic        valid_s1;
	dtd_s1_t     data_s1;
	dtd_s1_t     s1_next;
	dtd_s2_t     s2_next;
	logic [13:0] year_c;
	logic [3:0]  month_c;
	logic [6:0]  cent_prev;
	logic [6:0]  cent_year;
	logic        div4;
	logic        div100;

	// Clamp the year and month into range and start the divide-by-100 reciprocal products.
	always_comb begin
		if (year_number < 14'(YEAR_FIRST)) begin
			year_c = 14'(YEAR_FIRST);
		end else if (year_number > 14'(YEAR_LAST)) begin
			year_c = 14'(YEAR_LAST);
		end else begin
			year_c = year_number;
		end
		if (month_number < 4'(MONTH_FIRST)) begin
			month_c = 4'(MONTH_FIRST);
		end else if (month_number > 4'(MONTH_LAST)) begin
			month_c = 4'(MONTH_LAST);
		end else begin
			month_c = month_number;
		end
		s1_next.prev_year    = year_c - 14'd1;
		s1_next.prod_prev    = 24'(s1_next.prev_year[13:2]) * 24'(RECIP_25);
		s1_next.year_quarter = year_c[13:2];
		s1_next.prod_year    = 24'(year_c[13:2]) * 24'(RECIP_25);
		s1_next.year_low     = year_c[1:0];
		s1_next.month_index  = month_c - 4'd1;
		s1_next.day          = day_number;
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= s1_next;
		end
	end

	// Leap rule and closed-form day total of the years before this one.
	always_comb begin
		cent_prev = data_s1.prod_prev[RECIP_SHIFT +: 7];
		cent_year = data_s1.prod_year[RECIP_SHIFT +: 7];
		div4      = (data_s1.year_low == 2'd0);
		div100    = div4 && (data_s1.year_quarter == 12'(cent_year) * 12'd25);
		s2_next.leap = (div4 && !div100) || (div100 && (cent_year[1:0] == 2'd0));
		s2_next.year_days = 22'(data_s1.prev_year) * 22'(DAYS_PER_YEAR)
			+ 22'(data_s1.prev_year[13:2])
			- 22'(cent_prev)
			+ 22'(cent_prev[6:2])
			- 22'(DAYS_BEFORE_EPOCH);
		s2_next.month_index = data_s1.month_index;
		s2_next.day         = data_s1.day;
	end

	// Stage two registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= s2_next;
		end
	end

endmodule

`default_nettype wire

FILE: design/dtd_month_calc.sv
// Stage three: month offset, day count, first-of-month index and month length.
`default_nettype none

module dtd_month_calc (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             valid_s2,
	input  wire dtd_pkg::dtd_s2_t data_s2,
	output logic                  valid_s3,
	output dtd_pkg::dtd_s3_t      data_s3
);
	import dtd_pkg::*;

	dtd_s3_t     s3_next;
	logic [21:0] base;

	// Add the month offset, with the leap day after February.
	always_comb begin
		base = data_s2.year_days + 22'(days_before_month(data_s2.month_index))
			+ 22'(data_s2.leap && (data_s2.month_index > FEB_INDEX));
		s3_next.count       = base + 22'(data_s2.day);
		s3_next.first_index = base + 22'd1;
		s3_next.leap        = data_s2.leap;
		s3_next.month_length = (data_s2.leap && (data_s2.month_index == FEB_INDEX))
			? LEAP_FEB_LENGTH : plain_month_length(data_s2.month_index);
	end

	// Stage three registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s3 <= s3_next;
		end
	end

endmodule

`default_nettype wire

FILE: design/dtd_weekday_calc.sv
// Stage four: weekday reduction modulo seven and the output register.
`default_nettype none

module dtd_weekday_calc (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             valid_s3,
	input  wire dtd_pkg::dtd_s3_t data_s3,
	output logic                  valid_s4,
	output dtd_pkg::dtd_result_t  data_s4
);
	import dtd_pkg::*;

	dtd_result_t s4_next;

	// Day 1 of the count is a Thursday, so weekday is (count + 2) mod 7.
	always_comb begin
		s4_next.day_count    = data_s3.count;
		s4_next.weekday      = mod7(data_s3.count + 22'd2);
		s4_next.leap_year    = data_s3.leap;
		s4_next.month_length = data_s3.month_length;
		s4_next.first_column = mod7(data_s3.first_index + 22'd2);
	end

	// Output stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s4 <= s4_next;
		end
	end

endmodule

`default_nettype wire

FILE: design/date_to_day_count_weekday.sv
// Top level of the Gregorian date to day count and weekday converter.
//
//   Channel   Dir  Fields
//   date_in   in   day_number[4:0], month_number[3:0], year_number[13:0]
//   result    out  day_count[21:0], weekday[2:0], leap_year, month_length[4:0],
//                  first_column[2:0]
//
// One item is accepted per cycle unless the result side stalls. Each date passes through
// the four register stages in order: clamp and reciprocal products,
// year total and leap rule, month offset, and the modulo-seven reduction.
// Reset clears only the stage valid bits; the stage data registers are not reset.
// A stall on the result side freezes all stages together, so date_in.ready is low
// only while the output holds an item that is not taken.
`default_nettype none

module date_to_day_count_weekday (
	input wire logic clk,
	input wire logic arst_n,
	dtd_in_if.sink   date_in,
	dtd_out_if.source result
);
	import dtd_pkg::*;

	logic        adv;
	logic        valid_s2;
	logic        valid_s3;
	logic        valid_s4;
	dtd_s2_t     data_s2;
	dtd_s3_t     data_s3;
	dtd_result_t data_s4;

	// The pipeline moves whenever the output stage is empty or being taken.
	assign adv = !valid_s4 || result.ready;
	assign date_in.ready = adv;

	dtd_year_calc u_year (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (date_in.valid),
		.day_number   (date_in.day_number),
		.month_number (date_in.month_number),
		.year_number  (date_in.year_number),
		.valid_s2     (valid_s2),
		.data_s2      (data_s2)
	);

	dtd_month_calc u_month (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	dtd_weekday_calc u_weekday (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	// Drive the result channel from the output stage.
	assign result.valid        = valid_s4;
	assign result.day_count    = data_s4.day_count;
	assign result.weekday      = data_s4.weekday;
	assign result.leap_year    = data_s4.leap_year;
	assign result.month_length = data_s4.month_length;
	assign result.first_column = data_s4.first_column;

	// Weekday fields stay in the seven-day range on every valid result.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.weekday <= 3'd6) && (result.first_column <= 3'd6))
	else $error("weekday field out of range");

	// Only a leap year has a 29-day month, and no month is shorter than 28 days.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.month_length >= 5'd28)
			&& (result.leap_year || (result.month_length != LEAP_FEB_LENGTH)))
	else $error("month length inconsistent with leap flag");

	// An item taken while the third stage is full reaches the output on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && adv) |=> result.valid)
	else $error("item lost between stage three and output");

	// An item in the output stage that is not taken holds the whole pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !date_in.ready)
	else $error("input accepted while output stalled");

endmodule

`default_nettype wire
